@@ hw/rtl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assert_macros.svh
// assertion helpers, sampled on clk and disabled while rst_n is low
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hw/rtl/tbgc_pkg.sv @@
// ----------------------------------------------------------------------------
// tbgc_pkg
// shared types and constants of the two-key gesture classifier
// ----------------------------------------------------------------------------
package tbgc_pkg;

  localparam int unsigned TIME_W = 32;

  localparam logic [TIME_W-1:0] DEBOUNCE_RST = 32'd25000;
  localparam logic [TIME_W-1:0] LONG_RST     = 32'd900000;

  // configuration register index
  typedef enum logic [0:0] {
    CFG_DEBOUNCE = 1'b0,
    CFG_LONG     = 1'b1
  } cfg_reg_t;

  typedef logic [TIME_W-1:0] time_t;

  // one sample of the keys
  typedef struct packed {
    logic  key_a_level;
    logic  key_b_level;
    time_t now_us;
  } sample_t;

  // event flags of one sample
  typedef struct packed {
    logic next_event;
    logic increment_event;
    logic save_event;
    logic reset_event;
  } events_t;

  // current thresholds
  typedef struct packed {
    time_t debounce_time;
    time_t long_press_time;
  } thresholds_t;

endpackage

@@ hw/rtl/tbgc_cfg_regs.sv @@
// ----------------------------------------------------------------------------
// tbgc_cfg_regs
// debounce and long-press threshold registers
// ----------------------------------------------------------------------------
module tbgc_cfg_regs (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  wr_en,
  input  tbgc_pkg::cfg_reg_t    wr_index,
  input  tbgc_pkg::time_t       wr_data,
  output tbgc_pkg::thresholds_t thr
);

  tbgc_pkg::time_t debounce_r;
  tbgc_pkg::time_t long_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      debounce_r <= tbgc_pkg::DEBOUNCE_RST;
      long_r     <= tbgc_pkg::LONG_RST;
    end else if (wr_en) begin
      unique case (wr_index)
        tbgc_pkg::CFG_DEBOUNCE: debounce_r <= wr_data;
        tbgc_pkg::CFG_LONG:     long_r     <= wr_data;
        default: ;
      endcase
    end
  end

  assign thr.debounce_time   = debounce_r;
  assign thr.long_press_time = long_r;

endmodule

@@ hw/rtl/tbgc_classify.sv @@
// ----------------------------------------------------------------------------
// tbgc_classify
// gesture state and single-pass event logic for one sample
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module tbgc_classify (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  step,
  input  tbgc_pkg::sample_t     smp,
  input  tbgc_pkg::thresholds_t thr,
  output tbgc_pkg::events_t     ev
);

  logic            a_prev_r, a_prev_nxt;
  logic            b_prev_r, b_prev_nxt;
  tbgc_pkg::time_t a_pt_r, a_pt_nxt;
  tbgc_pkg::time_t b_pt_r, b_pt_nxt;
  logic            long_r, long_nxt;
  logic            chord_r, chord_nxt;

  logic ka, kb;
  logic a_fall, b_fall, chord_hit, chord_mid, long_mid;
  tbgc_pkg::time_t a_age_old, b_age_old, a_age, b_age;

  always_comb begin
    ka = smp.key_a_level;
    kb = smp.key_b_level;

    // chord uses press times from before this sample
    a_age_old = smp.now_us - a_pt_r;
    b_age_old = smp.now_us - b_pt_r;
    chord_hit = !ka && !a_prev_r && !kb && !b_prev_r && !chord_r &&
                (a_age_old > thr.long_press_time) &&
                (b_age_old > thr.long_press_time);
    chord_mid = chord_r | chord_hit;

    // latch press times on falling edges
    a_fall   = a_prev_r & ~ka;
    b_fall   = b_prev_r & ~kb;
    a_pt_nxt = a_fall ? smp.now_us : a_pt_r;
    b_pt_nxt = b_fall ? smp.now_us : b_pt_r;
    long_mid = b_fall ? 1'b0 : long_r;

    a_age = smp.now_us - a_pt_nxt;
    b_age = smp.now_us - b_pt_nxt;

    ev.reset_event = chord_hit;
    ev.save_event  = !kb && !long_mid && (b_age > thr.long_press_time);
    long_nxt       = long_mid | ev.save_event;

    ev.next_event      = !a_prev_r && ka && (a_age > thr.debounce_time) && !chord_mid;
    ev.increment_event = !b_prev_r && kb && (b_age > thr.debounce_time) &&
                         !long_nxt && !chord_mid;

    chord_nxt  = (ka && kb) ? 1'b0 : chord_mid;
    a_prev_nxt = ka;
    b_prev_nxt = kb;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_prev_r <= 1'b1;
      b_prev_r <= 1'b1;
      a_pt_r   <= '0;
      b_pt_r   <= '0;
      long_r   <= 1'b0;
      chord_r  <= 1'b0;
    end else if (step) begin
      a_prev_r <= a_prev_nxt;
      b_prev_r <= b_prev_nxt;
      a_pt_r   <= a_pt_nxt;
      b_pt_r   <= b_pt_nxt;
      long_r   <= long_nxt;
      chord_r  <= chord_nxt;
    end
  end

  `ASSERT_IMPL(a_chord_keys_down, step && ev.reset_event, !ka && !kb, "chord with key up")
  `ASSERT_IMPL(a_save_inc_excl, step, !(ev.save_event && ev.increment_event), "save and increment")
  `ASSERT_NEXT(a_long_after_save, step && ev.save_event, long_r, "long mark not set")

endmodule

@@ hw/rtl/two_button_gesture_classifier_top.sv @@
// ----------------------------------------------------------------------------
// two_button_gesture_classifier_top
// two-key gesture classifier: short releases, long hold and chord
// ----------------------------------------------------------------------------
// usage
//   in_*  : one sample word per handshake (key levels, active low, and a
//           free-running microsecond time that wraps)
//   out_* : one event word per sample, four flags that may be set together
//   cfg_* : write port for the debounce and long-press thresholds, index 0
//           and 1; always ready, write only while no sample is in flight
//   a word is taken at a clock edge with valid high and stall low
//   an accepted sample lands in the input register, and its events reach the
//   result register when that register is free or being drained;
//   throughput one sample per cycle while the receiver does not stall,
//   set by the single pass from the input register through the compare
//   logic into the result register
//   when the receiver stalls, the result register holds and the input
//   register keeps one more sample; in_stall rises only when both are full
//   reset (rst_n low, synchronous) empties both registers, restores default
//   thresholds and returns both keys to released with no pending marks
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module two_button_gesture_classifier_top (
  input  logic                  clk,
  input  logic                  rst_n,
  // sample channel
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic                  in_key_a_level,
  input  logic                  in_key_b_level,
  input  logic [31:0]           in_now_us,
  // event channel
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic                  out_next_event,
  output logic                  out_increment_event,
  output logic                  out_save_event,
  output logic                  out_reset_event,
  // configuration channel
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  tbgc_pkg::cfg_reg_t    cfg_index,
  input  logic [31:0]           cfg_data
);

  // input register
  logic                  in_full_r, in_full_nxt;
  tbgc_pkg::sample_t     smp_r;
  // result register
  logic                  out_valid_r, out_valid_nxt;
  tbgc_pkg::events_t     ev_r;

  tbgc_pkg::events_t     ev;
  tbgc_pkg::thresholds_t thr;
  logic                  advance;
  logic                  in_take;

  // sample moves to the result register when that is free or being drained
  assign advance  = in_full_r && (!out_valid_r || !out_stall);
  assign in_stall = in_full_r && !advance;
  assign in_take  = in_valid && !in_stall;

  assign cfg_ready = 1'b1;

  tbgc_cfg_regs u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .thr      (thr)
  );

  tbgc_classify u_cls (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (advance),
    .smp   (smp_r),
    .thr   (thr),
    .ev    (ev)
  );

  always_comb begin
    in_full_nxt   = in_take | (in_full_r & ~advance);
    out_valid_nxt = advance | (out_valid_r & out_stall);
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_full_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      in_full_r   <= in_full_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers, no reset needed
  always_ff @(posedge clk) begin
    if (in_take) begin
      smp_r.key_a_level <= in_key_a_level;
      smp_r.key_b_level <= in_key_b_level;
      smp_r.now_us      <= in_now_us;
    end
    if (advance) begin
      ev_r <= ev;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_next_event      = ev_r.next_event;
  assign out_increment_event = ev_r.increment_event;
  assign out_save_event      = ev_r.save_event;
  assign out_reset_event     = ev_r.reset_event;

  `ASSERT_IMPL(a_empty_no_stall, !in_full_r, !in_stall, "stall with empty input register")
  `ASSERT_NEXT(a_advance_fills, advance, out_valid_r, "result lost after advance")
  `ASSERT_IMPL(a_full_blocked, in_full_r && out_valid_r && out_stall, in_stall, "sample overrun")

endmodule

@@ test/tb_two_button_gesture_classifier_top.sv @@
// ----------------------------------------------------------------------------
// tb_two_button_gesture_classifier_top
// self-checking bench for the two-key gesture classifier: a queue-fed driver
// offers key samples, a transaction-level predictor works out the event flags of
// each accepted sample, and a monitor checks every event word in order, over
// several threshold settings including both extremes
// ----------------------------------------------------------------------------
module tb_two_button_gesture_classifier_top;
  timeunit 1ns;
  timeprecision 1ps;

  // ports of the block; the inputs are known from time zero
  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic                 in_key_a_level = 1'b1;
  logic                 in_key_b_level = 1'b1;
  logic [31:0]          in_now_us = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic                 out_next_event;
  logic                 out_increment_event;
  logic                 out_save_event;
  logic                 out_reset_event;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  tbgc_pkg::cfg_reg_t   cfg_index = tbgc_pkg::CFG_DEBOUNCE;
  logic [31:0]          cfg_data = '0;

  two_button_gesture_classifier_top dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_key_a_level      (in_key_a_level),
    .in_key_b_level      (in_key_b_level),
    .in_now_us           (in_now_us),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_next_event      (out_next_event),
    .out_increment_event (out_increment_event),
    .out_save_event      (out_save_event),
    .out_reset_event     (out_reset_event),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data)
  );

  always #2 clk = ~clk;

  // samples waiting to be offered, and event words still owed by the block
  tbgc_pkg::sample_t q_samples[$];
  tbgc_pkg::events_t q_owed_events[$];
  tbgc_pkg::sample_t offered;

  // predictor copy of the thresholds and of the key tracking state
  tbgc_pkg::time_t debounce_us = tbgc_pkg::DEBOUNCE_RST;
  tbgc_pkg::time_t long_us     = tbgc_pkg::LONG_RST;
  logic            prev_a = 1'b1;
  logic            prev_b = 1'b1;
  tbgc_pkg::time_t press_a = '0;
  tbgc_pkg::time_t press_b = '0;
  logic            hold_seen  = 1'b0;
  logic            chord_seen = 1'b0;

  // generator view of the sequence it has built so far
  logic            gen_prev_a = 1'b1;
  logic            gen_prev_b = 1'b1;
  tbgc_pkg::time_t gen_press_a = '0;
  tbgc_pkg::time_t gen_press_b = '0;
  tbgc_pkg::time_t gen_now = '0;

  int    n_mismatches = 0;
  int    results_seen = 0;
  int    cyc = 0;
  int    hold_left = 0;
  logic  hold_done = 1'b0;
  logic  calm;

  // a window with no idling on either side
  always @(posedge clk) cyc <= cyc + 1;
  assign calm = (cyc >= 1000) && (cyc < 1500);

  // event flags for one sample; the chord check sees the press times from
  // before this sample, the other checks see them after the falling edges
  function automatic tbgc_pkg::events_t predict_events(tbgc_pkg::sample_t s);
    tbgc_pkg::events_t ev;
    tbgc_pkg::time_t   held_a;
    tbgc_pkg::time_t   held_b;
    ev = '0;
    held_a = s.now_us - press_a;
    held_b = s.now_us - press_b;
    if (!s.key_a_level && !prev_a && !s.key_b_level && !prev_b && !chord_seen &&
        held_a > long_us && held_b > long_us) begin
      chord_seen = 1'b1;
      ev.reset_event = 1'b1;
    end
    if (prev_a && !s.key_a_level) press_a = s.now_us;
    if (prev_b && !s.key_b_level) begin
      press_b = s.now_us;
      hold_seen = 1'b0;
    end
    held_a = s.now_us - press_a;
    held_b = s.now_us - press_b;
    // long hold of key b is independent of any chord
    if (!s.key_b_level && !hold_seen && held_b > long_us) begin
      hold_seen = 1'b1;
      ev.save_event = 1'b1;
    end
    if (!prev_a && s.key_a_level && held_a > debounce_us && !chord_seen)
      ev.next_event = 1'b1;
    if (!prev_b && s.key_b_level && held_b > debounce_us && !hold_seen && !chord_seen)
      ev.increment_event = 1'b1;
    // the chord mark only clears once both keys are up
    if (s.key_a_level && s.key_b_level) chord_seen = 1'b0;
    prev_a = s.key_a_level;
    prev_b = s.key_b_level;
    return ev;
  endfunction

  // sender: predicts on acceptance, then offers the next word or idles
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) q_owed_events.push_back(predict_events(offered));
      if (!in_valid || !in_stall) begin
        if (q_samples.size() != 0 && (calm || $urandom_range(99) >= 14)) begin
          offered = q_samples.pop_front();
          in_key_a_level <= offered.key_a_level;
          in_key_b_level <= offered.key_b_level;
          in_now_us      <= offered.now_us;
          in_valid       <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // receiver stall: random, plus one long hold-off while samples are still
  // queued, so that both internal registers fill and in_stall rises
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (hold_left != 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (!hold_done && results_seen >= 300 && q_samples.size() > 40) begin
      out_stall <= 1'b1;
      hold_left <= 200;
      hold_done <= 1'b1;
    end else begin
      out_stall <= !calm && ($urandom_range(99) < 14);
    end
  end

  task automatic report_mismatch(string what, tbgc_pkg::events_t want,
                                 tbgc_pkg::events_t got);
    n_mismatches++;
    if (n_mismatches <= 10)
      $display("%0t: %s: exp next=%b inc=%b save=%b reset=%b, %s%b inc=%b save=%b reset=%b",
               $time, what, want.next_event, want.increment_event, want.save_event,
               want.reset_event, "got next=", got.next_event, got.increment_event,
               got.save_event, got.reset_event);
  endtask

  // monitor: every accepted event word against the oldest one owed
  always @(posedge clk) begin
    tbgc_pkg::events_t got;
    tbgc_pkg::events_t want;
    if (rst_n && out_valid && !out_stall) begin
      got.next_event      = out_next_event;
      got.increment_event = out_increment_event;
      got.save_event      = out_save_event;
      got.reset_event     = out_reset_event;
      results_seen <= results_seen + 1;
      if (q_owed_events.size() == 0) begin
        report_mismatch("event word with none owed", '0, got);
      end else begin
        want = q_owed_events.pop_front();
        if (got.next_event !== want.next_event ||
            got.increment_event !== want.increment_event ||
            got.save_event !== want.save_event ||
            got.reset_event !== want.reset_event)
          report_mismatch("event word mismatch", want, got);
      end
    end
  end

  // queue one sample and keep the generator's own edge tracking in step
  task automatic push_sample(logic ka, logic kb, tbgc_pkg::time_t t);
    tbgc_pkg::sample_t s;
    if (gen_prev_a && !ka) gen_press_a = t;
    if (gen_prev_b && !kb) gen_press_b = t;
    gen_prev_a = ka;
    gen_prev_b = kb;
    gen_now = t;
    s.key_a_level = ka;
    s.key_b_level = kb;
    s.now_us = t;
    q_samples.push_back(s);
  endtask

  // mostly plausible press and release sequences, with times aimed at the
  // debounce and long thresholds from the last presses; a little pure noise
  task automatic add_key_activity(int n);
    tbgc_pkg::time_t t;
    tbgc_pkg::time_t span;
    logic            ka;
    logic            kb;
    span = (long_us > 60000) ? 60000 : long_us;
    if ($urandom_range(3) == 0) gen_now = 32'hFFFF_0000 + $urandom_range(16'hFFFF);
    else gen_now = $urandom;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(99) < 8) begin
        push_sample(1'($urandom_range(1)), 1'($urandom_range(1)), $urandom);
      end else begin
        ka = gen_prev_a ^ ($urandom_range(99) < 25);
        kb = gen_prev_b ^ ($urandom_range(99) < 25);
        case ($urandom_range(6))
          0, 1: t = gen_now + $urandom_range(span);
          2:    t = gen_press_a + debounce_us + $urandom_range(1);
          3:    t = gen_press_b + debounce_us + $urandom_range(1);
          4:    t = gen_press_a + long_us + $urandom_range(1);
          5:    t = gen_press_b + long_us + $urandom_range(1);
          default: t = gen_now + $urandom_range(2);
        endcase
        push_sample(ka, kb, t);
      end
    end
  endtask

  // config write on its own channel; predictor follows on the write edge
  task automatic write_threshold(tbgc_pkg::cfg_reg_t which, tbgc_pkg::time_t value);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= which;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    if (which == tbgc_pkg::CFG_DEBOUNCE) debounce_us = value;
    else long_us = value;
    cfg_valid <= 1'b0;
  endtask

  task automatic set_thresholds(tbgc_pkg::time_t db, tbgc_pkg::time_t lp);
    write_threshold(tbgc_pkg::CFG_DEBOUNCE, db);
    write_threshold(tbgc_pkg::CFG_LONG, lp);
  endtask

  // nothing queued, nothing offered and nothing owed, then the pipe settles
  task automatic wait_idle();
    while (q_samples.size() != 0 || in_valid || q_owed_events.size() != 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  initial begin
    tbgc_pkg::time_t db;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // default thresholds straight out of reset
    push_sample(1, 1, 1000);
    push_sample(0, 1, 2000);
    push_sample(1, 1, 27000);           // release exactly at debounce: silent
    push_sample(0, 1, 30000);
    push_sample(1, 1, 55001);           // one past debounce: next
    push_sample(1, 0, 100000);
    push_sample(1, 1, 125001);          // short b release: increment
    push_sample(1, 0, 200000);
    push_sample(1, 0, 1100000);         // exactly long: no save yet
    push_sample(1, 0, 1100001);         // save
    push_sample(1, 0, 1200000);         // save only once per press
    push_sample(1, 1, 1200100);         // release after long hold: silent
    push_sample(0, 0, 2000000);
    push_sample(0, 0, 2900001);         // chord and long hold together
    push_sample(0, 0, 3000000);
    push_sample(1, 0, 3000100);         // a released inside a chord: silent
    push_sample(0, 0, 3000200);
    push_sample(1, 1, 3100000);         // both up clears the chord mark
    push_sample(0, 1, 32'hFFFF_FFF0);
    push_sample(1, 1, 32'h0000_7000);   // press time wraps
    push_sample(1, 0, 32'h0000_8000);
    push_sample(0, 0, 32'h0000_9000);
    push_sample(1, 0, 32'h0000_9000 + 25001);
    push_sample(1, 1, 32'h0001_0000);
    wait_idle();

    // both thresholds at zero
    set_thresholds(32'd0, 32'd0);
    push_sample(0, 0, 5000);
    push_sample(0, 0, 5000);            // zero hold is not above zero
    push_sample(0, 0, 5001);
    push_sample(1, 1, 5001);
    push_sample(0, 1, 5005);
    push_sample(1, 1, 5005);
    push_sample(0, 1, 5006);
    push_sample(1, 1, 5007);
    add_key_activity(120);
    wait_idle();

    // both thresholds at the top: no release, hold or chord can fire
    set_thresholds(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    push_sample(0, 0, 7);
    push_sample(0, 0, 6);               // held for the largest difference
    push_sample(1, 1, 6);
    add_key_activity(120);
    wait_idle();

    // small thresholds so that sequences cross them often
    for (int k = 0; k < 4; k++) begin
      db = $urandom_range(2000);
      set_thresholds(db, db + $urandom_range(30000, 500));
      add_key_activity(180);
      wait_idle();
    end

    // debounce longer than the long hold
    set_thresholds(32'd20000, 32'd3000);
    add_key_activity(150);
    wait_idle();

    // any values at all
    set_thresholds($urandom, $urandom);
    add_key_activity(150);
    wait_idle();

    // back to the reset values
    set_thresholds(tbgc_pkg::DEBOUNCE_RST, tbgc_pkg::LONG_RST);
    add_key_activity(150);
    wait_idle();
    repeat (8) @(posedge clk);

    if (n_mismatches == 0 && q_owed_events.size() == 0) begin
      $display("tb_two_button_gesture_classifier_top: PASS");
    end else begin
      $display("tb_two_button_gesture_classifier_top: FAIL");
    end
    $finish;
  end

  // hang guard
  initial begin
    #2000000;
    $display("tb_two_button_gesture_classifier_top: FAIL");
    $finish;
  end

endmodule
